FILE: sv/first_fit_heap_allocator_macros.svh
// Assertion helpers shared by the allocator RTL
`ifndef FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH

// Implication checked on every clock, off while in reset
`define FFHA_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, off while in reset
`define FFHA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: sv/ffha_pkg.sv
package ffha_pkg;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_OOM  = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    localparam int REQ_W  = 21;
    localparam int OFF_W  = 20;
    localparam int STAT_W = 2;

endpackage

FILE: sv/first_fit_heap_allocator.sv
// First-fit heap allocator: keeps the free extents of the heap in an
// address-ordered table (two RAMs, one entry read and one written per cycle)
// and the granted block sizes in a RAM indexed by block start / UNIT_BYTES.
// One word is taken at a time; s_axis_tready is low while it is at work.
// An allocate scans the table one extent at a time (S_SREAD, S_SCAN) until
// the first fit, then trims that extent, or removes it by shifting the tail
// down one entry at a time (S_SHDN_R, S_SHDN_W) when the rest would be too
// small; a free reads its recorded size, scans to its place and, when it
// neither merges nor fills a gap, shifts the tail up one entry at a time
// (S_SHUP_R, S_SHUP_W).
// The result waits in the output register; the next word is taken the cycle
// after it has left. No clearing pass is needed after reset.
module first_fit_heap_allocator #(
    parameter int HEAP_BYTES   = 1048576,
    parameter int UNIT_BYTES   = 64,
    parameter int HEADER_BYTES = 16,
    parameter int MAX_EXTENTS  = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] action, [21:1] request_bytes, [41:22] release_offset, [47:42] zero
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [19:0] user_offset, [40:20] block_bytes, [42:41] status, [47:43] zero
    output logic [47:0] m_axis_tdata
);
    import ffha_pkg::*;
    `include "first_fit_heap_allocator_macros.svh"

    localparam int UNIT_SH  = $clog2(UNIT_BYTES);
    localparam int STORE_D  = HEAP_BYTES / UNIT_BYTES;
    localparam int STORE_AW = $clog2(STORE_D);
    localparam int EXT_AW   = $clog2(MAX_EXTENTS);
    localparam int CNT_W    = $clog2(MAX_EXTENTS + 1);
    // internal arithmetic width, holds heap size plus a request
    localparam int AW       = $clog2(HEAP_BYTES) + 3;

    localparam logic [AW-1:0] HEAP_A   = AW'(HEAP_BYTES);
    localparam logic [AW-1:0] UNIT_A   = AW'(UNIT_BYTES);
    localparam logic [AW-1:0] HDR_A    = AW'(HEADER_BYTES);
    localparam logic [AW-1:0] UMASK_A  = AW'(UNIT_BYTES - 1);
    localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_EXTENTS);

    typedef enum logic [3:0] {
        S_IDLE, S_SREAD, S_SCAN, S_DEC, S_PREV, S_SHDN_R, S_SHDN_W,
        S_SHUP_R, S_SHUP_W, S_PUT, S_SZRD, S_SZWT, S_OUT
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             act_reg, act_next;
    logic [AW-1:0]    need_reg, need_next;
    logic [AW-1:0]    blk_reg, blk_next;
    logic [AW-1:0]    size_reg, size_next;
    logic [AW-1:0]    cs_reg, cs_next;      // current extent start
    logic [AW-1:0]    cl_reg, cl_next;      // current extent length
    logic [AW-1:0]    pend_reg, pend_next;  // previous extent end
    logic             hasp_reg, hasp_next;
    logic             init_reg, init_next;  // entry 0 not yet written
    logic [47:0]      out_reg, out_next;
    logic             ov_reg, ov_next;

    // extent table and size store
    logic              ext_we;
    logic [EXT_AW-1:0] ext_wa, ext_ra;
    logic [AW-1:0]     ws, wl, rs_raw, rl_raw, rs, rl;
    logic              st_we;
    logic [STORE_AW-1:0] st_wa, st_ra;
    logic [REQ_W-1:0]  st_wd, st_rd;

    ffha_ram #(.WIDTH(AW), .DEPTH(MAX_EXTENTS)) u_start (
        .aclk, .we(ext_we), .waddr(ext_wa), .wdata(ws), .raddr(ext_ra), .rdata(rs_raw));
    ffha_ram #(.WIDTH(AW), .DEPTH(MAX_EXTENTS)) u_len (
        .aclk, .we(ext_we), .waddr(ext_wa), .wdata(wl), .raddr(ext_ra), .rdata(rl_raw));
    ffha_ram #(.WIDTH(REQ_W), .DEPTH(STORE_D)) u_size (
        .aclk, .we(st_we), .waddr(st_wa), .wdata(st_wd), .raddr(st_ra), .rdata(st_rd));

    logic rd_init_reg;  // last read was entry 0 before first write
    assign rs = rd_init_reg ? '0 : rs_raw;
    assign rl = rd_init_reg ? HEAP_A : rl_raw;

    logic [AW-1:0] req_a, off_a, need_raw, rem;
    assign req_a    = AW'(s_axis_tdata[21:1]);
    assign off_a    = AW'(s_axis_tdata[41:22]);
    assign need_raw = (req_a + HDR_A + UMASK_A) & ~UMASK_A;
    assign rem      = cl_reg - need_reg;

    assign s_axis_tready = (state_reg == S_IDLE) && !ov_reg;
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = out_reg;

    function automatic logic [47:0] pack(logic [AW-1:0] o, logic [AW-1:0] b, status_t s);
        return {5'd0, s, b[REQ_W-1:0], o[OFF_W-1:0]};
    endfunction

    always_comb begin
        state_next = state_reg; count_next = count_reg; idx_next = idx_reg;
        act_next = act_reg; need_next = need_reg; blk_next = blk_reg;
        size_next = size_reg; cs_next = cs_reg; cl_next = cl_reg;
        pend_next = pend_reg; hasp_next = hasp_reg; init_next = init_reg;
        out_next = out_reg; ov_next = ov_reg;
        ext_we = 1'b0; ext_wa = '0; ws = '0; wl = '0;
        ext_ra = idx_reg[EXT_AW-1:0];
        st_we = 1'b0; st_wa = blk_reg[UNIT_SH +: STORE_AW];
        st_ra = blk_reg[UNIT_SH +: STORE_AW];
        st_wd = size_reg[REQ_W-1:0];
        if (ov_reg && m_axis_tready) begin
            ov_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (s_axis_tvalid && s_axis_tready) begin
                    act_next  = s_axis_tdata[0];
                    idx_next  = '0;
                    hasp_next = 1'b0;
                    ext_ra    = '0;
                    if (s_axis_tdata[0] == ACT_ALLOC) begin
                        need_next  = (need_raw == '0) ? UNIT_A : need_raw;
                        state_next = S_SREAD;
                    end else if (off_a < HDR_A || off_a - HDR_A >= HEAP_A) begin
                        out_next   = pack('0, '0, ST_OK);
                        ov_next    = 1'b1;
                    end else begin
                        blk_next   = off_a - HDR_A;
                        state_next = S_SZRD;
                    end
                end
            end
            S_SZRD: state_next = S_SZWT;
            S_SZWT: begin
                size_next = AW'(st_rd);
                if (count_reg >= MAX_C) begin
                    out_next   = pack('0, AW'(st_rd), ST_FULL);
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end else begin
                    state_next = S_SREAD;
                end
            end
            // read address idx was presented last cycle
            S_SREAD: state_next = S_SCAN;
            S_SCAN: begin
                if (idx_reg >= count_reg) begin
                    if (act_reg == ACT_ALLOC) begin
                        out_next   = pack('0, '0, ST_OOM);
                        ov_next    = 1'b1;
                        state_next = S_IDLE;
                    end else begin
                        state_next = S_DEC;
                    end
                end else if ((act_reg == ACT_ALLOC && rl >= need_reg) ||
                             (act_reg == ACT_FREE && rs >= blk_reg)) begin
                    cs_next = rs; cl_next = rl;
                    state_next = S_DEC;
                end else begin
                    pend_next = rs + rl;
                    hasp_next = 1'b1;
                    idx_next  = idx_reg + 1'b1;
                    ext_ra    = EXT_AW'(idx_reg + 1'b1);
                    state_next = S_SREAD;
                end
            end
            S_DEC: begin
                if (act_reg == ACT_ALLOC) begin
                    st_wa = cs_reg[UNIT_SH +: STORE_AW];
                    st_we = (cs_reg >> UNIT_SH) < AW'(STORE_D);
                    if (rem < UNIT_A + HDR_A) begin
                        st_wd    = cl_reg[REQ_W-1:0];
                        out_next = pack(cs_reg + HDR_A, cl_reg, ST_OK);
                        state_next = S_SHDN_R;
                    end else begin
                        st_wd  = need_reg[REQ_W-1:0];
                        ext_we = 1'b1; ext_wa = idx_reg[EXT_AW-1:0];
                        ws = cs_reg + need_reg; wl = rem;
                        out_next = pack(cs_reg + HDR_A, need_reg, ST_OK);
                        ov_next = 1'b1; state_next = S_IDLE;
                    end
                end else begin
                    out_next = pack('0, size_reg, ST_OK);
                    if (hasp_reg && pend_reg == blk_reg) begin
                        if (idx_reg < count_reg && blk_reg + size_reg == cs_reg) begin
                            // merge both sides into previous, drop current
                            size_next = size_reg + cl_reg;
                        end
                        ext_ra = EXT_AW'(idx_reg - 1'b1);
                        state_next = S_PREV;
                    end else if (idx_reg < count_reg && blk_reg + size_reg == cs_reg) begin
                        ext_we = 1'b1; ext_wa = idx_reg[EXT_AW-1:0];
                        ws = blk_reg; wl = size_reg + cl_reg;
                        ov_next = 1'b1; state_next = S_IDLE;
                    end else begin
                        // open a slot at idx: shift tail up, top first
                        cs_next = AW'(count_reg);
                        ext_ra  = EXT_AW'(count_reg - 1'b1);
                        state_next = (count_reg == idx_reg) ? S_PUT : S_SHUP_R;
                    end
                end
            end
            S_PREV: begin
                ext_we = 1'b1; ext_wa = EXT_AW'(idx_reg - 1'b1);
                ws = rs; wl = rl + size_reg;
                if (size_next != size_reg || (idx_reg < count_reg &&
                    blk_reg + out_reg[40:20] == cs_reg && cl_reg != '0 &&
                    size_reg != AW'(out_reg[40:20]))) begin
                    state_next = S_SHDN_R;
                end else begin
                    ov_next = 1'b1; state_next = S_IDLE;
                end
                if (size_reg != AW'(out_reg[40:20])) begin
                    state_next = S_SHDN_R;
                    ov_next = 1'b0;
                end
            end
            // remove entry idx: copy idx+1 down
            S_SHDN_R: begin
                if (idx_reg + 1'b1 >= count_reg) begin
                    count_next = count_reg - 1'b1;
                    ov_next = 1'b1; state_next = S_IDLE;
                end else begin
                    ext_ra = EXT_AW'(idx_reg + 1'b1);
                    state_next = S_SHDN_W;
                end
            end
            S_SHDN_W: begin
                ext_we = 1'b1; ext_wa = idx_reg[EXT_AW-1:0]; ws = rs; wl = rl;
                idx_next = idx_reg + 1'b1;
                state_next = S_SHDN_R;
            end
            // copy entry cs-1 up into cs
            S_SHUP_R: begin
                ext_ra = EXT_AW'(cs_reg - 1'b1);
                state_next = S_SHUP_W;
            end
            S_SHUP_W: begin
                ext_we = 1'b1; ext_wa = cs_reg[EXT_AW-1:0]; ws = rs; wl = rl;
                cs_next = cs_reg - 1'b1;
                state_next = (cs_reg - 1'b1 == AW'(idx_reg)) ? S_PUT : S_SHUP_R;
            end
            S_PUT: begin
                ext_we = 1'b1; ext_wa = idx_reg[EXT_AW-1:0];
                ws = blk_reg; wl = size_reg;
                count_next = count_reg + 1'b1;
                ov_next = 1'b1; state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
        if (ext_we && ext_wa == '0) begin
            init_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE; count_reg <= CNT_W'(1); ov_reg <= 1'b0;
            init_reg <= 1'b1; rd_init_reg <= 1'b0;
        end else begin
            state_reg <= state_next; count_reg <= count_next; ov_reg <= ov_next;
            init_reg <= init_next;
            rd_init_reg <= init_next && (ext_ra == '0);
        end
        idx_reg <= idx_next; act_reg <= act_next; need_reg <= need_next;
        blk_reg <= blk_next; size_reg <= size_next; cs_reg <= cs_next;
        cl_reg <= cl_next; pend_reg <= pend_next; hasp_reg <= hasp_next;
        out_reg <= out_next;
    end

    `FFHA_ASSERT_IMPL(a_cnt_range, aclk, aresetn, 1'b1, count_reg <= MAX_C)
    `FFHA_ASSERT_IMPL(a_busy, aclk, aresetn, state_reg != S_IDLE, !s_axis_tready)
    `FFHA_ASSERT_NEXT(a_hold, aclk, aresetn, ov_reg && !m_axis_tready, ov_reg && $stable(out_reg))

endmodule

FILE: sv/ffha_ram.sv
module ffha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
